[sv/bse_pkg.sv]
`timescale 1ns / 1ps
// Package for the burning-ship escape-time engine: fixed-point formats,
// field widths and configuration register indexes. No dependencies.
package bse_pkg;

   localparam int FRAC_BITS = 28;
   localparam int OUT_FRAC  = 24;
   localparam int MAX_SIDE  = 4096;
   localparam int PIX_W     = 12;
   localparam int COORD_W   = 32;
   localparam int STEP_W    = 31;
   localparam int PAN_W     = 16;
   localparam int ITER_W    = 16;
   localparam int MAG_W     = 32;

   // Iterates are nonnegative and below 2^(COORD_W-1).
   localparam int IT_W      = COORD_W - 1;
   localparam int PROD_W    = 2 * COORD_W;
   localparam int SQ_W      = 2 * IT_W - FRAC_BITS;
   localparam int SUM_W     = SQ_W + 1;
   localparam int DIFF_W    = SUM_W + 2;
   localparam int MAP_W     = PROD_W - 15;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_X_ORIGIN   = 3'd0,
      REG_Y_ORIGIN   = 3'd1,
      REG_X_STEP     = 3'd2,
      REG_Y_STEP     = 3'd3,
      REG_PAN_X      = 3'd4,
      REG_PAN_Y      = 3'd5,
      REG_ITER_LIMIT = 3'd6,
      REG_UNUSED     = 3'd7
   } reg_idx_type;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;

endpackage

[sv/burning_ship_escape_time.sv]
`timescale 1ns / 1ps
// Burning-ship escape-time engine: maps a pixel to a complex point and iterates.
// Depends on bse_pkg for formats, widths and register indexes.
//
//   Channel  Direction  Handshake             Beat contents
//   req      in         req_tvalid/tready     pixel_x, pixel_y
//   rsp      out        rsp_tvalid/tready     iterations, magnitude_sq; escaped in tuser
//   csr      in         psel/penable/pready   seven configuration registers
//
// A single 32x32 multiplier serves re*im, re*re and im*im in turn within each
// iteration, and the coordinate mapping. Reset is synchronous and loads the
// register defaults. A result waiting on rsp does not block the next req beat;
// the engine only holds its finished result until the output register is free.
module burning_ship_escape_time (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bse_pkg::REQ_DATA_W-1:0]      req_tdata,  // pixel_x, pixel_y
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bse_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // iterations, magnitude_sq
   output logic                                rsp_tuser,  // escaped
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bse_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [bse_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [bse_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import bse_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MAP_X, ST_MAP_Y, ST_MAP_C, ST_LOOP,
      ST_UPD, ST_SQ_RE, ST_SQ_IM, ST_SQ_END, ST_DONE
   } state_type;

   function automatic logic [IT_W-1:0] abs_sat(input logic signed [DIFF_W-1:0] v);
      logic [DIFF_W-1:0] mag;
      mag = v[DIFF_W-1] ? (~v + 1'b1) : v;
      return (|mag[DIFF_W-1:IT_W]) ? {IT_W{1'b1}} : mag[IT_W-1:0];
   endfunction

   state_type                  state_ff, state_in;
   logic [COORD_W-1:0]         x_origin_ff, y_origin_ff;
   logic [STEP_W-1:0]          x_step_ff, y_step_ff;
   logic [PAN_W-1:0]           pan_x_ff, pan_y_ff;
   logic [ITER_W-1:0]          iter_limit_ff;

   logic [PIX_W-1:0]           px_ff, py_ff;
   logic [COORD_W-1:0]         c_re_ff, c_im_ff;
   logic [IT_W-1:0]            re_ff, im_ff;
   logic [SQ_W-1:0]            re_sq_ff, im_sq_ff;
   logic [ITER_W-1:0]          iter_ff;
   logic signed [PROD_W-1:0]   prod_ff;

   logic                       rsp_valid_ff;
   logic [ITER_W-1:0]          rsp_iter_ff;
   logic [MAG_W-1:0]           rsp_mag_ff;
   logic                       rsp_esc_ff;

   logic                       csr_write;
   reg_idx_type                csr_idx;
   logic signed [PAN_W:0]      col, row;
   logic signed [COORD_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0]   mul_p;
   logic signed [MAP_W-1:0]    map_sum;
   logic [COORD_W-1:0]         map_sat;
   logic [SUM_W-1:0]           sum;
   logic                       escape;
   logic signed [DIFF_W-1:0]   im_diff, re_diff;
   logic                       out_free;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      case (csr_idx)
         REG_X_ORIGIN:   csr_prdata = x_origin_ff;
         REG_Y_ORIGIN:   csr_prdata = y_origin_ff;
         REG_X_STEP:     csr_prdata = {1'b0, x_step_ff};
         REG_Y_STEP:     csr_prdata = {1'b0, y_step_ff};
         REG_PAN_X:      csr_prdata = {{(CSR_DATA_W-PAN_W){1'b0}}, pan_x_ff};
         REG_PAN_Y:      csr_prdata = {{(CSR_DATA_W-PAN_W){1'b0}}, pan_y_ff};
         REG_ITER_LIMIT: csr_prdata = {{(CSR_DATA_W-ITER_W){1'b0}}, iter_limit_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign col = $signed({1'b0, px_ff}) + $signed({pan_x_ff[PAN_W-1], pan_x_ff});
   assign row = $signed({1'b0, py_ff}) + $signed({pan_y_ff[PAN_W-1], pan_y_ff});

   always_comb begin
      case (state_ff)
         ST_MAP_X: begin
            mul_a = COORD_W'(col);
            mul_b = $signed({1'b0, x_step_ff});
         end
         ST_MAP_Y: begin
            mul_a = COORD_W'(row);
            mul_b = $signed({1'b0, y_step_ff});
         end
         ST_SQ_RE: begin
            mul_a = $signed({1'b0, re_ff});
            mul_b = $signed({1'b0, re_ff});
         end
         ST_SQ_IM: begin
            mul_a = $signed({1'b0, im_ff});
            mul_b = $signed({1'b0, im_ff});
         end
         default: begin
            mul_a = $signed({1'b0, re_ff});
            mul_b = $signed({1'b0, im_ff});
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      if (state_ff == ST_MAP_C) begin
         map_sum = $signed({{(MAP_W-COORD_W){y_origin_ff[COORD_W-1]}}, y_origin_ff})
                 - $signed(prod_ff[MAP_W-1:0]);
      end else begin
         map_sum = $signed({{(MAP_W-COORD_W){x_origin_ff[COORD_W-1]}}, x_origin_ff})
                 + $signed(prod_ff[MAP_W-1:0]);
      end
      if (!map_sum[MAP_W-1] && (|map_sum[MAP_W-2:COORD_W-1])) begin
         map_sat = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (map_sum[MAP_W-1] && !(&map_sum[MAP_W-2:COORD_W-1])) begin
         map_sat = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         map_sat = map_sum[COORD_W-1:0];
      end
   end

   assign sum    = {1'b0, re_sq_ff} + {1'b0, im_sq_ff};
   assign escape = |sum[SUM_W-1:FRAC_BITS+2];

   assign im_diff = $signed({{(DIFF_W-(2*IT_W-FRAC_BITS+1)){1'b0}},
                             prod_ff[2*IT_W-1:FRAC_BITS-1]})
                  - $signed({{(DIFF_W-COORD_W){c_im_ff[COORD_W-1]}}, c_im_ff});
   assign re_diff = $signed({{(DIFF_W-SQ_W){1'b0}}, re_sq_ff})
                  - $signed({{(DIFF_W-SQ_W){1'b0}}, im_sq_ff})
                  + $signed({{(DIFF_W-COORD_W){c_re_ff[COORD_W-1]}}, c_re_ff});

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      case (state_ff)
         ST_IDLE:   state_in = (req_tvalid && req_tready) ? ST_MAP_X : ST_IDLE;
         ST_MAP_X:  state_in = ST_MAP_Y;
         ST_MAP_Y:  state_in = ST_MAP_C;
         ST_MAP_C:  state_in = ST_LOOP;
         ST_LOOP:   state_in = (!escape && iter_ff < iter_limit_ff) ? ST_UPD : ST_DONE;
         ST_UPD:    state_in = ST_SQ_RE;
         ST_SQ_RE:  state_in = ST_SQ_IM;
         ST_SQ_IM:  state_in = ST_SQ_END;
         ST_SQ_END: state_in = ST_LOOP;
         ST_DONE:   state_in = out_free ? ST_IDLE : ST_DONE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         x_origin_ff   <= 32'hE000_0000;
         y_origin_ff   <= 32'h2000_0000;
         x_step_ff     <= 31'd1048576;
         y_step_ff     <= 31'd1048576;
         pan_x_ff      <= '0;
         pan_y_ff      <= '0;
         iter_limit_ff <= 16'd256;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            case (csr_idx)
               REG_X_ORIGIN:   x_origin_ff   <= csr_pwdata[COORD_W-1:0];
               REG_Y_ORIGIN:   y_origin_ff   <= csr_pwdata[COORD_W-1:0];
               REG_X_STEP:     x_step_ff     <= csr_pwdata[STEP_W-1:0];
               REG_Y_STEP:     y_step_ff     <= csr_pwdata[STEP_W-1:0];
               REG_PAN_X:      pan_x_ff      <= csr_pwdata[PAN_W-1:0];
               REG_PAN_Y:      pan_y_ff      <= csr_pwdata[PAN_W-1:0];
               REG_ITER_LIMIT: iter_limit_ff <= csr_pwdata[ITER_W-1:0];
               default: ;
            endcase
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      case (state_ff)
         ST_IDLE: begin
            px_ff    <= (req_tdata[PIX_W-1:0] > PIX_W'(MAX_SIDE - 1))
                        ? PIX_W'(MAX_SIDE - 1) : req_tdata[PIX_W-1:0];
            py_ff    <= (req_tdata[2*PIX_W-1:PIX_W] > PIX_W'(MAX_SIDE - 1))
                        ? PIX_W'(MAX_SIDE - 1) : req_tdata[2*PIX_W-1:PIX_W];
            re_ff    <= '0;
            im_ff    <= '0;
            re_sq_ff <= '0;
            im_sq_ff <= '0;
            iter_ff  <= '0;
         end
         ST_MAP_Y:  c_re_ff  <= map_sat;
         ST_MAP_C:  c_im_ff  <= map_sat;
         ST_UPD: begin
            im_ff   <= abs_sat(im_diff);
            re_ff   <= abs_sat(re_diff);
            iter_ff <= iter_ff + 1'b1;
         end
         ST_SQ_IM:  re_sq_ff <= prod_ff[2*IT_W-1:FRAC_BITS];
         ST_SQ_END: im_sq_ff <= prod_ff[2*IT_W-1:FRAC_BITS];
         ST_DONE: begin
            if (out_free) begin
               rsp_iter_ff <= iter_ff;
               rsp_esc_ff  <= escape;
               rsp_mag_ff  <= {{(MAG_W-(SUM_W-(FRAC_BITS-OUT_FRAC))){1'b0}},
                               sum[SUM_W-1:FRAC_BITS-OUT_FRAC]};
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_mag_ff, rsp_iter_ff};
   assign rsp_tuser  = rsp_esc_ff;

endmodule
